[rtl/core/cvcu_pkg.sv]
package cvcu_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_ROM_LEN     = 24;
  localparam int DAT_W            = 36;
  localparam int OUT_W            = 25;

  // Angles are radians in Q30.
  localparam logic signed [DAT_W-1:0] PI_Q30            = 36'sd3373259426;
  localparam logic signed [DAT_W-1:0] HALF_PI_Q30       = 36'sd1686629713;
  localparam logic signed [DAT_W-1:0] THREE_HALF_PI_Q30 = 36'sd5059889139;
  localparam logic signed [DAT_W-1:0] TWO_PI_Q30        = 36'sd6746518852;

  // Inverse CORDIC gain in Q30.
  localparam logic [29:0] GAIN_Q30 = 30'd652032874;

  // Heading to radians: h * P / 11520 = h * A + h * B / 11520, and the
  // remainder term is divided by 256 and then by 45 through a reciprocal.
  localparam logic [18:0] HD_A_PI    = 19'd292817;
  localparam logic [12:0] HD_B_PI    = 13'd7586;
  localparam logic [18:0] HD_A_314   = 19'd292669;
  localparam logic [12:0] HD_B_314   = 13'd2447;
  localparam logic [20:0] HD_RECIP   = 21'd1491309;

  typedef enum logic [1:0] {
    MODE_ZERO_FORCE = 2'd0,
    MODE_NO_MOVE    = 2'd1,
    MODE_LOCATING   = 2'd2,
    MODE_REMOTE     = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    REG_MODE        = 3'd0,
    REG_SPEED_GAIN  = 3'd1,
    REG_TURN_GAIN   = 3'd2,
    REG_SPEED_LIMIT = 3'd3,
    REG_TURN_LIMIT  = 3'd4,
    REG_SPEED_STEP  = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic start;
    logic vectoring;
  } cordic_ctl_t;

  function automatic logic [29:0] atan_rom(input logic [4:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:  v = 30'd843314856;
      5'd1:  v = 30'd497837829;
      5'd2:  v = 30'd263043836;
      5'd3:  v = 30'd133525158;
      5'd4:  v = 30'd67021686;
      5'd5:  v = 30'd33543515;
      5'd6:  v = 30'd16775850;
      5'd7:  v = 30'd8388437;
      5'd8:  v = 30'd4194282;
      5'd9:  v = 30'd2097149;
      5'd10: v = 30'd1048575;
      5'd11: v = 30'd524287;
      5'd12: v = 30'd262143;
      5'd13: v = 30'd131071;
      5'd14: v = 30'd65535;
      5'd15: v = 30'd32767;
      5'd16: v = 30'd16383;
      5'd17: v = 30'd8191;
      5'd18: v = 30'd4095;
      5'd19: v = 30'd2047;
      5'd20: v = 30'd1023;
      5'd21: v = 30'd511;
      5'd22: v = 30'd255;
      5'd23: v = 30'd127;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [DAT_W-1:0] v);
    logic signed [OUT_W-1:0] r;
    if (v > 36'sd16777215) begin
      r = 25'sd16777215;
    end else if (v < -36'sd16777216) begin
      r = -25'sd16777216;
    end else begin
      r = OUT_W'(v);
    end
    return r;
  endfunction

endpackage

[rtl/core/cvcu_cordic.sv]
module cvcu_cordic import cvcu_pkg::*; #(
  parameter int STEPS = CORDIC_STEPS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  cordic_ctl_t             ctl,
  input  logic signed [DAT_W-1:0] x_in,
  input  logic signed [DAT_W-1:0] y_in,
  input  logic signed [DAT_W-1:0] z_in,
  output logic signed [DAT_W-1:0] x_out,
  output logic signed [DAT_W-1:0] y_out,
  output logic signed [DAT_W-1:0] z_out,
  output logic                    done
);

  localparam logic [4:0] LAST = 5'(STEPS - 1);

  typedef enum logic [3:0] {
    C_IDLE = 4'b0001,
    C_RED  = 4'b0010,
    C_HALF = 4'b0100,
    C_ITER = 4'b1000
  } cstate_t;

  cstate_t                 state;
  logic                    vec;
  logic [4:0]              i;
  logic signed [DAT_W-1:0] x, y, z;
  logic signed [DAT_W-1:0] xs, ys, rom, x_next, y_next, z_next;
  logic                    up;

  // One micro-rotation per cycle. Vectoring steers y toward zero, rotation
  // steers the residual angle toward zero; both share the same add paths.
  always_comb begin
    xs     = x >>> i;
    ys     = y >>> i;
    rom    = $signed({6'b0, atan_rom(i)});
    up     = vec ? (y > 36'sd0) : (z < 36'sd0);
    x_next = up ? x + ys : x - ys;
    y_next = up ? y - xs : y + xs;
    z_next = up ? z + rom : z - rom;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      vec   <= 1'b0;
      i     <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        C_IDLE: begin
          if (ctl.start) begin
            x     <= x_in;
            y     <= y_in;
            z     <= z_in;
            i     <= '0;
            vec   <= ctl.vectoring;
            state <= ctl.vectoring ? C_ITER : C_RED;
          end
        end
        C_RED: begin
          if (z > PI_Q30) begin
            z <= z - TWO_PI_Q30;
          end else if (z <= -PI_Q30) begin
            z <= z + TWO_PI_Q30;
          end else begin
            state <= C_HALF;
          end
        end
        C_HALF: begin
          if (z > HALF_PI_Q30) begin
            z <= z - PI_Q30;
            x <= -x;
            y <= -y;
          end else if (z < -HALF_PI_Q30) begin
            z <= z + PI_Q30;
            x <= -x;
            y <= -y;
          end
          state <= C_ITER;
        end
        C_ITER: begin
          x <= x_next;
          y <= y_next;
          z <= z_next;
          i <= i + 5'd1;
          if (i == LAST) begin
            state <= C_IDLE;
            done  <= 1'b1;
          end
        end
        default: state <= C_IDLE;
      endcase
    end
  end

  assign x_out = x;
  assign y_out = y;
  assign z_out = z;

endmodule

[rtl/core/chassis_velocity_command_unit.sv]
// Channel   Direction  Handshake            Beat contents
// in        inbound    in_valid / in_stall  sticks, gimbal yaw, target and current pose
// out       outbound   out_valid / out_stall  vx_out, vy_out, w_out, drive_off
// cfg       inbound    cfg_we (no wait)     cfg_index, cfg_data
//
// One beat is worked on at a time. Remote mode runs a heading conversion and a
// rotation CORDIC pass, locating two heading conversions, a vectoring pass and a
// rotation pass of CORDIC_STEPS micro-rotations each, and the hold and stop modes
// go straight to the output. The CORDIC unit and the single multiplier set the pace.
// The result sits in an output register, so a new beat is taken while the last
// result still waits on out_stall. Reset is synchronous and restores the
// register defaults and clears the held commands and the speed history.
module chassis_velocity_command_unit import cvcu_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [15:0]      stick_forward,
  input  logic signed [15:0]      stick_side,
  input  logic signed [15:0]      stick_turn,
  input  logic signed [15:0]      gimbal_yaw,
  input  logic signed [23:0]      target_x,
  input  logic signed [23:0]      target_y,
  input  logic signed [15:0]      target_heading,
  input  logic signed [23:0]      current_x,
  input  logic signed [23:0]      current_y,
  input  logic signed [15:0]      current_heading,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [OUT_W-1:0] vx_out,
  output logic signed [OUT_W-1:0] vy_out,
  output logic signed [OUT_W-1:0] w_out,
  output logic                    drive_off,
  input  logic                    cfg_we,
  input  logic [2:0]              cfg_index,
  input  logic [15:0]             cfg_data
);

  // Sequencer states. The multiplier result is registered, so each state
  // sets up one product that the following state consumes.
  typedef enum logic [18:0] {
    ST_IDLE     = 19'h00001,
    ST_RX       = 19'h00002,
    ST_RY       = 19'h00004,
    ST_HA       = 19'h00008,
    ST_HB       = 19'h00010,
    ST_HC       = 19'h00020,
    ST_HD       = 19'h00040,
    ST_VEC_GO   = 19'h00080,
    ST_VEC_WAIT = 19'h00100,
    ST_D1       = 19'h00200,
    ST_D2       = 19'h00400,
    ST_D3       = 19'h00800,
    ST_TQ       = 19'h01000,
    ST_S1       = 19'h02000,
    ST_S2       = 19'h04000,
    ST_RMUL     = 19'h08000,
    ST_ROT_GO   = 19'h10000,
    ST_ROT_WAIT = 19'h20000,
    ST_DONE     = 19'h40000
  } state_t;

  // Which heading the shared conversion sequence is working on.
  typedef enum logic [1:0] {
    HD_YAW = 2'd0,
    HD_TGT = 2'd1,
    HD_CUR = 2'd2
  } hd_sel_t;

  state_t  state;
  hd_sel_t hsel;
  mode_t   lmode;

  // Configuration registers.
  mode_t       mode;
  logic [7:0]  speed_gain;
  logic [15:0] turn_gain;
  logic [9:0]  speed_limit;
  logic [9:0]  turn_limit;
  logic [9:0]  speed_step;

  // Persistent state.
  logic [23:0]             last_speed;
  logic signed [OUT_W-1:0] held_vx, held_vy, held_w;

  // Beat captured at acceptance.
  logic signed [15:0] sf, ss, st, yaw, thd, chd;
  logic signed [24:0] dx, dy;

  // Working registers.
  logic signed [DAT_W-1:0] rx_r, ry_r, ang, th, ch, xm, tvec;
  logic [33:0]             hp1;
  logic [47:0]             dacc;
  logic [33:0]             distance;
  logic [23:0]             fl, ce;
  logic                    ge;
  logic [9:0]              vc;

  // Shared multiplier.
  logic signed [DAT_W-1:0] mul_a;
  logic signed [31:0]      mul_b;
  logic signed [67:0]      mul_p;
  logic                    mul_en;

  // CORDIC unit.
  cordic_ctl_t             cctl;
  logic signed [DAT_W-1:0] c_x_in, c_y_in, c_z_in, c_x, c_y, c_z;
  logic                    c_done;

  logic                    accept;
  logic                    load_out;
  logic signed [15:0]      h_val;
  logic                    hneg;
  logic signed [16:0]      h_ext;
  logic [16:0]             habs;
  logic [18:0]             hd_a;
  logic [12:0]             hd_b;
  logic [DAT_W-1:0]        hq;
  logic signed [DAT_W-1:0] hres;
  logic signed [DAT_W-1:0] err;
  logic [24:0]             dxa;
  logic signed [24:0]      yv;
  logic signed [DAT_W-1:0] s_ang, base_ang;
  logic [63:0]             dsum;
  logic [41:0]             tq;
  logic [42:0]             tqc;
  logic [25:0]             fl_full;
  logic [26:0]             ce_full;
  logic [23:0]             inc, incl, v0;
  logic signed [DAT_W-1:0] wt, wl, wclamp;
  logic signed [OUT_W-1:0] w_remote;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  // The output register takes a new beat once it is empty or being drained.
  assign load_out = (state == ST_DONE) && (!out_valid || !out_stall);

  // Heading conversion operands.
  always_comb begin
    case (hsel)
      HD_YAW:  h_val = yaw;
      HD_TGT:  h_val = thd;
      default: h_val = chd;
    endcase
    hneg  = h_val[15];
    h_ext = $signed({h_val[15], h_val});
    habs  = hneg ? 17'(-h_ext) : 17'(h_ext);
    hd_a  = (hsel == HD_YAW) ? HD_A_314 : HD_A_PI;
    hd_b  = (hsel == HD_YAW) ? HD_B_314 : HD_B_PI;
    // Truncation toward zero: convert the magnitude, then restore the sign.
    hq    = DAT_W'(hp1) + DAT_W'(mul_p[40:26]);
    hres  = hneg ? -$signed(hq) : $signed(hq);
  end

  assign err = th - ch;

  // Multiplier operand selection.
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    case (state)
      ST_RX: begin
        mul_a = $signed({{20{sf[15]}}, sf});
        mul_b = $signed({2'b0, GAIN_Q30});
      end
      ST_RY: begin
        mul_a = $signed({{20{ss[15]}}, ss});
        mul_b = $signed({2'b0, GAIN_Q30});
      end
      ST_HA: begin
        mul_a = $signed({19'b0, habs});
        mul_b = $signed({13'b0, hd_a});
      end
      ST_HB: begin
        mul_a = $signed({19'b0, habs});
        mul_b = $signed({19'b0, hd_b});
      end
      ST_HC: begin
        mul_a = $signed({16'b0, mul_p[27:8]});
        mul_b = $signed({11'b0, HD_RECIP});
      end
      ST_D1: begin
        mul_a = $signed({18'b0, xm[17:0]});
        mul_b = $signed({2'b0, GAIN_Q30});
      end
      ST_D2: begin
        mul_a = $signed({19'b0, xm[34:18]});
        mul_b = $signed({2'b0, GAIN_Q30});
      end
      ST_TQ: begin
        mul_a = $signed({2'b0, distance});
        mul_b = $signed({24'b0, speed_gain});
      end
      ST_RMUL: begin
        mul_a = $signed({26'b0, vc});
        mul_b = $signed({2'b0, GAIN_Q30});
      end
      ST_ROT_GO: begin
        mul_a = err;
        mul_b = $signed({16'b0, turn_gain});
      end
      default: mul_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      mul_p <= mul_a * mul_b;
    end
  end

  // Locating: vectoring input, drive angle and speed shaping.
  always_comb begin
    dxa = dx[24] ? 25'(-dx) : 25'(dx);
    yv  = dx[24] ? -dy : dy;
    if (dx == 25'sd0) begin
      s_ang = HALF_PI_Q30;
    end else if (dy == 25'sd0) begin
      s_ang = '0;
    end else if (dx[24] ^ dy[24]) begin
      s_ang = tvec + PI_Q30;
    end else begin
      s_ang = tvec;
    end
    base_ang = (dy > 25'sd0) ? HALF_PI_Q30 : THREE_HALF_PI_Q30;

    dsum    = {16'b0, dacc} + {mul_p[45:0], 18'b0};
    tq      = mul_p[41:0];
    tqc     = {1'b0, tq} + 43'h0FFFF;
    fl_full = tq[41:16];
    ce_full = tqc[42:16];

    inc  = fl - last_speed;
    incl = (inc > {14'b0, speed_step}) ? {14'b0, speed_step} : inc;
    v0   = ge ? last_speed + incl : ce;

    wt     = mul_p[57:22];
    wl     = $signed({18'b0, turn_limit, 8'b0});
    if (wt > wl) begin
      wclamp = wl;
    end else if (wt < -wl) begin
      wclamp = -wl;
    end else begin
      wclamp = wt;
    end
    w_remote = -$signed({st[15], st, 8'b0});
  end

  // CORDIC requests.
  always_comb begin
    cctl.start     = (state == ST_VEC_GO) || (state == ST_ROT_GO);
    cctl.vectoring = (state == ST_VEC_GO);
    if (state == ST_VEC_GO) begin
      c_x_in = $signed({3'b0, dxa, 8'b0});
      c_y_in = $signed({{3{yv[24]}}, yv, 8'b0});
      c_z_in = '0;
    end else if (lmode == MODE_REMOTE) begin
      c_x_in = rx_r;
      c_y_in = ry_r;
      c_z_in = ang;
    end else begin
      c_x_in = mul_p[49:14];
      c_y_in = '0;
      c_z_in = ang;
    end
  end

  cvcu_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .ctl   (cctl),
    .x_in  (c_x_in),
    .y_in  (c_y_in),
    .z_in  (c_z_in),
    .x_out (c_x),
    .y_out (c_y),
    .z_out (c_z),
    .done  (c_done)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_REMOTE;
      speed_gain  <= 8'd3;
      turn_gain   <= 16'd1500;
      speed_limit <= 10'd200;
      turn_limit  <= 10'd200;
      speed_step  <= 10'd50;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:        mode        <= mode_t'(cfg_data[1:0]);
        REG_SPEED_GAIN:  speed_gain  <= cfg_data[7:0];
        REG_TURN_GAIN:   turn_gain   <= cfg_data;
        REG_SPEED_LIMIT: speed_limit <= cfg_data[9:0];
        REG_TURN_LIMIT:  turn_limit  <= cfg_data[9:0];
        REG_SPEED_STEP:  speed_step  <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // Beat capture and working registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      sf  <= stick_forward;
      ss  <= stick_side;
      st  <= stick_turn;
      yaw <= gimbal_yaw;
      thd <= target_heading;
      chd <= current_heading;
      dx  <= $signed({target_x[23], target_x}) - $signed({current_x[23], current_x});
      dy  <= $signed({target_y[23], target_y}) - $signed({current_y[23], current_y});
    end
    case (state)
      ST_RY: rx_r <= mul_p[49:14];
      ST_HA: begin
        if (hsel == HD_YAW) begin
          ry_r <= mul_p[49:14];
        end
      end
      ST_HB: hp1 <= mul_p[33:0];
      ST_HD: begin
        case (hsel)
          HD_YAW:  ang <= hres;
          HD_TGT:  th  <= hres;
          default: ch  <= hres;
        endcase
      end
      ST_VEC_WAIT: begin
        xm   <= c_x;
        tvec <= c_z;
      end
      ST_D1: ang <= base_ang - s_ang - ch;
      ST_D2: dacc <= mul_p[47:0];
      ST_D3: distance <= (xm > 36'sd0) ? dsum[63:30] : 34'd0;
      ST_S1: begin
        fl <= (|fl_full[25:24]) ? 24'hFFFFFF : fl_full[23:0];
        ce <= (|ce_full[26:24]) ? 24'hFFFFFF : ce_full[23:0];
        ge <= tq >= {2'b0, last_speed, 16'b0};
      end
      ST_S2: vc <= (v0 > {14'b0, speed_limit}) ? speed_limit : v0[9:0];
      default: ;
    endcase
  end

  // Sequencer, held commands and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      hsel       <= HD_YAW;
      lmode      <= MODE_REMOTE;
      last_speed <= '0;
      held_vx    <= '0;
      held_vy    <= '0;
      held_w     <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            lmode <= mode;
            case (mode)
              MODE_ZERO_FORCE: state <= ST_DONE;
              MODE_NO_MOVE: begin
                held_vx <= '0;
                held_vy <= '0;
                held_w  <= '0;
                state   <= ST_DONE;
              end
              MODE_LOCATING: begin
                hsel  <= HD_TGT;
                state <= ST_HA;
              end
              default: state <= ST_RX;
            endcase
          end
        end
        ST_RX: state <= ST_RY;
        ST_RY: begin
          hsel  <= HD_YAW;
          state <= ST_HA;
        end
        ST_HA: state <= ST_HB;
        ST_HB: state <= ST_HC;
        ST_HC: state <= ST_HD;
        ST_HD: begin
          case (hsel)
            HD_YAW: state <= ST_ROT_GO;
            HD_TGT: begin
              hsel  <= HD_CUR;
              state <= ST_HA;
            end
            default: state <= ST_VEC_GO;
          endcase
        end
        ST_VEC_GO: state <= ST_VEC_WAIT;
        ST_VEC_WAIT: begin
          if (c_done) begin
            state <= ST_D1;
          end
        end
        ST_D1: state <= ST_D2;
        ST_D2: state <= ST_D3;
        ST_D3: state <= ST_TQ;
        ST_TQ: state <= ST_S1;
        ST_S1: state <= ST_S2;
        ST_S2: begin
          last_speed <= v0;
          state      <= ST_RMUL;
        end
        ST_RMUL: state <= ST_ROT_GO;
        ST_ROT_GO: state <= ST_ROT_WAIT;
        ST_ROT_WAIT: begin
          if (c_done) begin
            if (lmode == MODE_REMOTE) begin
              held_vx <= sat_out($signed({{8{c_x[35]}}, c_x[35:8]}));
              held_vy <= sat_out($signed({{8{c_y[35]}}, c_y[35:8]}));
              held_w  <= w_remote;
            end else begin
              held_vx <= sat_out($signed({{8{c_y[35]}}, c_y[35:8]}));
              held_vy <= sat_out($signed({{8{c_x[35]}}, c_x[35:8]}));
              held_w  <= sat_out(wclamp);
            end
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (load_out) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      vx_out    <= held_vx;
      vy_out    <= held_vy;
      w_out     <= held_w;
      drive_off <= (lmode == MODE_ZERO_FORCE);
    end
  end

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps

// Self-checking bench for the chassis velocity command unit.
// Every accepted beat is run through a bit-exact predictor that holds its own
// copy of the registers, the speed history and the held commands. Each result
// beat is checked against the oldest prediction, field by field.
module testbench;
  import cvcu_pkg::*;

  // Fixed-point constants of the command math. Angles are radians in Q30.
  localparam longint PI_RAD     = 64'sd3373259426;
  localparam longint HALF_PI    = 64'sd1686629713;
  localparam longint TWO_PI     = 64'sd6746518852;
  // The remote path converts the gimbal yaw with 3.14 in place of pi.
  localparam longint PI_314     = 64'sd3371549327;
  localparam longint CORDIC_INV = 64'sd652032874;
  localparam longint DEG_DIV    = 64'sd11520;
  localparam longint SAT_HI     = 64'sd16777215;
  localparam longint SAT_LO     = -64'sd16777216;
  localparam int     STEPS      = CORDIC_STEPS_DEF;
  localparam longint ATAN_Q30 [24] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
    65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127};

  // A register index beyond the map; the block must ignore writes to it.
  localparam logic [2:0] REG_NONE = 3'd7;

  // Cycles without any accepted beat before the run is declared hung.
  localparam int QUIET_LIMIT = 4000;
  localparam int SETTLE      = 80;
  localparam int PHASES      = 12;
  localparam int PHASE_BEATS = 60;

  typedef struct packed {
    logic signed [15:0] fwd;
    logic signed [15:0] side;
    logic signed [15:0] turn;
    logic signed [15:0] yaw;
    logic signed [23:0] tx;
    logic signed [23:0] ty;
    logic signed [15:0] th;
    logic signed [23:0] cx;
    logic signed [23:0] cy;
    logic signed [15:0] ch;
  } tick_t;

  typedef struct packed {
    logic signed [24:0] vx;
    logic signed [24:0] vy;
    logic signed [24:0] w;
    logic               off;
  } command_t;

  // Holds the predicted commands and compares the block's output with them.
  class command_scoreboard;
    mode_t       mode;
    logic [7:0]  speed_gain;
    logic [15:0] turn_gain;
    logic [9:0]  speed_limit;
    logic [9:0]  turn_limit;
    logic [9:0]  speed_step;
    longint unsigned last_speed;
    longint held_vx, held_vy, held_w;
    command_t pending_cmds[$];
    int mismatches;
    int checked;

    function void reset_state();
      mode = MODE_REMOTE;
      speed_gain = 8'd3;
      turn_gain = 16'd1500;
      speed_limit = 10'd200;
      turn_limit = 10'd200;
      speed_step = 10'd50;
      last_speed = 0;
      held_vx = 0;
      held_vy = 0;
      held_w = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] val);
      case (idx)
        REG_MODE:        mode = mode_t'(val[1:0]);
        REG_SPEED_GAIN:  speed_gain = val[7:0];
        REG_TURN_GAIN:   turn_gain = val;
        REG_SPEED_LIMIT: speed_limit = val[9:0];
        REG_TURN_LIMIT:  turn_limit = val[9:0];
        REG_SPEED_STEP:  speed_step = val[9:0];
        default: ;
      endcase
    endfunction

    function longint to_rad(longint h, longint pi_val);
      return h * pi_val / DEG_DIV;
    endfunction

    function longint clip(longint v);
      if (v > SAT_HI) return SAT_HI;
      if (v < SAT_LO) return SAT_LO;
      return v;
    endfunction

    // Vectoring pass: drives y to zero and returns the angle swept.
    function longint vector_pass(inout longint x, inout longint y);
      longint xs, ys, z;
      z = 0;
      for (int i = 0; i < STEPS; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y > 0) begin
          x += ys; y -= xs; z += ATAN_Q30[i];
        end else begin
          x -= ys; y += xs; z -= ATAN_Q30[i];
        end
      end
      return z;
    endfunction

    // Rotation pass, gain left in. The angle is folded into the half plane
    // first; a half turn there negates the vector.
    function void rotate_pass(inout longint x, inout longint y, input longint a);
      longint xs, ys, ang;
      ang = a % TWO_PI;
      if (ang > PI_RAD) ang -= TWO_PI;
      if (ang <= -PI_RAD) ang += TWO_PI;
      if (ang > HALF_PI) begin
        ang -= PI_RAD; x = -x; y = -y;
      end else if (ang < -HALF_PI) begin
        ang += PI_RAD; x = -x; y = -y;
      end
      for (int i = 0; i < STEPS; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (ang >= 0) begin
          x -= ys; y += xs; ang -= ATAN_Q30[i];
        end else begin
          x += ys; y -= xs; ang += ATAN_Q30[i];
        end
      end
    endfunction

    function void predict_locating(tick_t b, output longint vx, output longint vy,
                                   output longint w);
      longint dx, dy, th, ch, sdx, xm, ym, t, s, c, rx, ry, err, wt, wl;
      longint unsigned distance, tq, fl, ce, v0, vc, inc;
      dx = longint'(b.tx) - longint'(b.cx);
      dy = longint'(b.ty) - longint'(b.cy);
      th = to_rad(longint'(b.th), PI_RAD);
      ch = to_rad(longint'(b.ch), PI_RAD);
      sdx = (dx < 0) ? -1 : 1;
      xm = ((dx < 0) ? -dx : dx) * 256;
      ym = dy * sdx * 256;
      t = vector_pass(xm, ym);

      // Speed: rises by at most speed_step per tick, falls freely.
      distance = (xm > 0) ? ((unsigned'(xm) * unsigned'(CORDIC_INV)) >> 30) : 0;
      tq = 64'(speed_gain) * distance;
      fl = tq >> 16;
      ce = (tq + 64'hFFFF) >> 16;
      if (fl > 64'hFFFFFF) fl = 64'hFFFFFF;
      if (ce > 64'hFFFFFF) ce = 64'hFFFFFF;
      if (tq >= (last_speed << 16)) begin
        inc = fl - last_speed;
        if (inc > 64'(speed_step)) inc = 64'(speed_step);
        v0 = last_speed + inc;
      end else begin
        v0 = ce;
      end
      last_speed = v0 & 64'hFFFFFF;
      vc = (v0 > 64'(speed_limit)) ? 64'(speed_limit) : v0;

      // Direction, including the away-from-target quirk straight ahead on +x.
      if (dx == 0) s = HALF_PI;
      else if (dy == 0) s = 0;
      else if (dy * sdx < 0) s = t + PI_RAD;
      else s = t;
      c = ((dy > 0) ? HALF_PI : 3 * HALF_PI) - s - ch;
      rx = (longint'(vc) * 65536 * CORDIC_INV) >>> 30;
      ry = 0;
      rotate_pass(rx, ry, c);
      vx = ry >>> 8;
      vy = rx >>> 8;

      err = th - ch;
      wt = (longint'(turn_gain) * err) >>> 22;
      wl = longint'(turn_limit) * 256;
      if (wt > wl) wt = wl;
      if (wt < -wl) wt = -wl;
      w = wt;
    endfunction

    function void note_beat(tick_t b);
      command_t cmd;
      longint vx, vy, w, x, y;
      vx = 0; vy = 0; w = 0;
      if (mode == MODE_ZERO_FORCE) begin
        cmd.vx = 25'(held_vx);
        cmd.vy = 25'(held_vy);
        cmd.w = 25'(held_w);
        cmd.off = 1'b1;
      end else begin
        if (mode == MODE_LOCATING) begin
          predict_locating(b, vx, vy, w);
        end else if (mode == MODE_REMOTE) begin
          x = (longint'(b.fwd) * 65536 * CORDIC_INV) >>> 30;
          y = (longint'(b.side) * 65536 * CORDIC_INV) >>> 30;
          rotate_pass(x, y, to_rad(longint'(b.yaw), PI_314));
          vx = x >>> 8;
          vy = y >>> 8;
          w = -longint'(b.turn) * 256;
        end
        held_vx = clip(vx);
        held_vy = clip(vy);
        held_w = clip(w);
        cmd.vx = 25'(held_vx);
        cmd.vy = 25'(held_vy);
        cmd.w = 25'(held_w);
        cmd.off = 1'b0;
      end
      pending_cmds.push_back(cmd);
    endfunction

    function void check_result(command_t got);
      command_t want;
      if (pending_cmds.size() == 0) begin
        $error("command beat with nothing expected: vx %0d vy %0d w %0d off %0b",
               got.vx, got.vy, got.w, got.off);
        mismatches++;
        return;
      end
      want = pending_cmds.pop_front();
      checked++;
      if (got.vx !== want.vx) begin
        $error("vx_out: expected %0d, got %0d", want.vx, got.vx);
        mismatches++;
      end
      if (got.vy !== want.vy) begin
        $error("vy_out: expected %0d, got %0d", want.vy, got.vy);
        mismatches++;
      end
      if (got.w !== want.w) begin
        $error("w_out: expected %0d, got %0d", want.w, got.w);
        mismatches++;
      end
      if (got.off !== want.off) begin
        $error("drive_off: expected %0b, got %0b", want.off, got.off);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic in_valid, in_stall, out_valid, out_stall;
  tick_t drv;
  logic signed [OUT_W-1:0] vx_out, vy_out, w_out;
  logic drive_off;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [15:0] cfg_data;

  command_scoreboard sb;
  int hold_req;
  int stall_style;
  int rx_cyc;
  int quiet;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  chassis_velocity_command_unit u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .stick_forward(drv.fwd), .stick_side(drv.side), .stick_turn(drv.turn),
    .gimbal_yaw(drv.yaw), .target_x(drv.tx), .target_y(drv.ty),
    .target_heading(drv.th), .current_x(drv.cx), .current_y(drv.cy),
    .current_heading(drv.ch),
    .out_valid(out_valid), .out_stall(out_stall),
    .vx_out(vx_out), .vy_out(vy_out), .w_out(w_out), .drive_off(drive_off),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Receiver. A hold-off request from the stimulus wins over the stall
  // pattern of the current phase; its length is counted here.
  initial begin
    out_stall = 1'b0;
    rx_cyc = 0;
    forever begin
      @(negedge clk);
      rx_cyc++;
      if (hold_req > 0) begin
        out_stall <= 1'b1;
        repeat (hold_req) @(negedge clk);
        hold_req = 0;
        out_stall <= 1'b0;
      end else begin
        case (stall_style)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ((rx_cyc % 7) < 3);
          default: out_stall <= ($urandom_range(0, 4) < 3);
        endcase
      end
    end
  end

  // Result beats are checked at the edge that accepts them.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result('{vx: vx_out, vy: vy_out, w: w_out, off: drive_off});
  end

  // Watchdog: counts cycles in which no beat moves on either channel.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Offers one beat and returns once it has been taken. Valid stays high, so
  // a following call goes straight on with the next beat.
  task automatic send_tick(tick_t b);
    @(negedge clk);
    drv <= b;
    in_valid <= 1'b1;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    sb.note_beat(b);
  endtask

  task automatic sender_gap(int n);
    if (n > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // Stops offering and waits until every predicted command has come back,
  // then lets the block settle so that it is idle for a register write.
  task automatic drain_commands();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending_cmds.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  function automatic tick_t remote_tick(int f, int s, int t, int y);
    tick_t b;
    b = '0;
    b.fwd = 16'(f); b.side = 16'(s); b.turn = 16'(t); b.yaw = 16'(y);
    return b;
  endfunction

  function automatic tick_t pose_tick(int tx, int ty, int th, int cx, int cy, int ch);
    tick_t b;
    b = '0;
    b.tx = 24'(tx); b.ty = 24'(ty); b.th = 16'(th);
    b.cx = 24'(cx); b.cy = 24'(cy); b.ch = 16'(ch);
    return b;
  endfunction

  // Biased toward the ends of the range, small values and zero.
  function automatic logic [15:0] pick16();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3, 4: return 16'($urandom_range(0, 400) - 200);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [23:0] pick24();
    case ($urandom_range(0, 7))
      0: return 24'h800000;
      1: return 24'h7FFFFF;
      2: return 24'h000000;
      default: return 24'($urandom);
    endcase
  endfunction

  // Mostly a target a modest distance from the current pose, so the speed
  // ramp and the limit both show up; sometimes reached, on an axis or far.
  function automatic tick_t random_tick();
    tick_t b;
    int near;
    b.fwd = pick16(); b.side = pick16(); b.turn = pick16(); b.yaw = pick16();
    b.th = pick16(); b.ch = pick16();
    b.cx = pick24(); b.cy = pick24();
    near = 1 << $urandom_range(4, 17);
    b.tx = b.cx + 24'($urandom_range(0, 2 * near) - near);
    b.ty = b.cy + 24'($urandom_range(0, 2 * near) - near);
    case ($urandom_range(0, 9))
      0: begin b.tx = b.cx; b.ty = b.cy; end
      1: b.ty = b.cy;
      2: b.tx = b.cx;
      3: begin b.tx = pick24(); b.ty = pick24(); end
      default: ;
    endcase
    return b;
  endfunction

  initial begin
    logic [15:0] rv [6];
    mode_t phase_modes [PHASES];
    int sent, burst;

    phase_modes = '{MODE_LOCATING, MODE_REMOTE, MODE_ZERO_FORCE,
                    MODE_LOCATING, MODE_NO_MOVE, MODE_REMOTE,
                    MODE_LOCATING, MODE_LOCATING, MODE_REMOTE,
                    MODE_ZERO_FORCE, MODE_LOCATING, MODE_REMOTE};
    rst = 1'b1;
    in_valid = 1'b0;
    drv = '0;
    cfg_we = 1'b0;
    cfg_index = REG_MODE;
    cfg_data = '0;
    hold_req = 0;
    stall_style = 0;
    sb = new();
    sb.reset_state();
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // Directed: remote mode after reset, sticks and yaw at their ends.
    send_tick(remote_tick(32767, 32767, 32767, 0));
    send_tick(remote_tick(-32768, -32768, -32768, -32768));
    send_tick(remote_tick(32767, -32768, 0, 32767));
    send_tick(remote_tick(100, 0, -1, 5760));
    send_tick(remote_tick(0, 100, 1, 11520));
    send_tick(remote_tick(-5, 7, 0, -11520));

    // Locating: reached, straight ahead on +x, on the y axis both ways,
    // behind, the farthest pose, then reached again so the speed falls.
    drain_commands();
    write_reg(REG_MODE, 16'(MODE_LOCATING));
    send_tick(pose_tick(0, 0, 0, 0, 0, 0));
    send_tick(pose_tick(25600, 0, 0, 0, 0, 0));
    send_tick(pose_tick(0, 25600, 640, 0, 0, 0));
    send_tick(pose_tick(0, -25600, 0, 0, 0, -640));
    send_tick(pose_tick(-25600, -12800, 0, 0, 0, 0));
    send_tick(pose_tick(8388607, 8388607, 32767, -8388608, -8388608, -32768));
    send_tick(pose_tick(-8388608, 8388607, -32768, 8388607, -8388608, 32767));
    send_tick(pose_tick(1000, 1000, 100, 1000, 1000, 100));

    // No move, then zero force which must repeat those zero commands, then a
    // write to an unmapped index that must leave the mode alone.
    drain_commands();
    write_reg(REG_MODE, 16'(MODE_NO_MOVE));
    send_tick(remote_tick(32767, 32767, 32767, 0));
    drain_commands();
    write_reg(REG_MODE, 16'(MODE_ZERO_FORCE));
    write_reg(REG_NONE, 16'hFFFF);
    send_tick(random_tick());
    send_tick(random_tick());

    // Random phases, each with its own register setting and stall pattern.
    // The first two settings are the extremes; some writes carry bits above
    // the register width to show that they are dropped.
    for (int p = 0; p < PHASES; p++) begin
      drain_commands();
      for (int r = 0; r < 6; r++) begin
        if (p == 0) rv[r] = 16'hFFFF;
        else if (p == 1) rv[r] = 16'h0000;
        else if ($urandom_range(0, 4) == 0) rv[r] = 16'($urandom);
        else rv[r] = 16'($urandom_range(0, 300));
      end
      rv[REG_MODE] = 16'(phase_modes[p]);
      for (int r = 0; r < 6; r++) write_reg(3'(r), rv[r]);
      stall_style = p % 4;

      // One phase starts with a long receiver hold-off while beats keep coming,
      // so the output register fills and the input backs up.
      if (p == 4) hold_req = 400;

      sent = 0;
      while (sent < PHASE_BEATS) begin
        burst = $urandom_range(1, 12);
        for (int k = 0; k < burst && sent < PHASE_BEATS; k++) begin
          send_tick(random_tick());
          sent++;
        end
        if ($urandom_range(0, 3) != 0) sender_gap($urandom_range(1, 40));
      end
    end

    drain_commands();
    if (sb.pending_cmds.size() > 0) begin
      $error("%0d expected command beats never arrived", sb.pending_cmds.size());
      sb.mismatches++;
    end
    $display("Checked %0d command beats across %0d register settings,", sb.checked,
             PHASES + 4);
    $display("covering zero force, no move, locating and remote under stalls.");
    if (sb.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
